/* rtl/core/clock_time_set_controller_assert.svh */
// Assertion macros shared by the clock/time-set controller RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef CLOCK_TIME_SET_CONTROLLER_ASSERT_SVH
`define CLOCK_TIME_SET_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CTSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CTSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ctsc_pkg.sv */
// Package for the clock/time-set controller: payload types, register indexes,
// mode and LED codes, reset values. No dependencies.
`default_nettype none

package ctsc_pkg;

  // Field widths
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PHASE_OUT_W = 5;
  localparam int unsigned LED_W    = 2;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TO_SET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 2'd2;

  // Setting modes; MODE_DONE only exists transiently before wrapping to clock
  localparam logic [MODE_W-1:0] MODE_CLOCK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOUR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MINUTE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd3;

  localparam logic [LED_W-1:0] LED_OFF = 2'd3;

  // Request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // Limits and reset values
  localparam logic [HOUR_W-1:0]    HOUR_MAX     = 5'd23;
  localparam logic [MINUTE_W-1:0]  MINUTE_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]    HOUR_RESET   = 5'd8;
  localparam logic [HOLD_W-1:0]    HOLD_SAT     = 8'd255;
  localparam logic [TIMEOUT_W-1:0] IDLE_LIMIT_RESET  = 16'd300;
  localparam logic [HOLD_W-1:0]    HOLD_TO_SET_RESET = 8'd60;
  localparam logic [HOLD_W-1:0]    SHORT_PRESS_RESET = 8'd15;
  localparam int unsigned          MINUTE_PHASE = 15;

  typedef struct packed {
    logic                req_type;
    logic                button_down;
    logic [HOUR_W-1:0]   rtc_hour;
    logic [MINUTE_W-1:0] rtc_minute;
  } req_t;

  typedef struct packed {
    logic [HOUR_W-1:0]      shown_hour;
    logic [MINUTE_W-1:0]    shown_minute;
    logic [MODE_W-1:0]      mode;
    logic [PHASE_OUT_W-1:0] colon_phase;
    logic [LED_W-1:0]       led_color;
    logic                   rtc_write;
    logic                   display_on;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/ctsc_chan_if.sv */
// Valid/ready channel carrying one payload struct per transaction.
// Payload type comes from ctsc_pkg (req_t or res_t).
`default_nettype none

interface ctsc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/clock_time_set_controller.sv */
// Latency: a result is valid the cycle after its request transaction is accepted.
// Throughput: one request per cycle; the result register frees as it is taken,
// so a request is accepted whenever the result slot is empty or being drained.
// Reset (synchronous, rst high): time 08:00, clock mode, awake counter zero,
// registers 300 / 60 / 15, result slot empty. Uses ctsc_pkg, ctsc_chan_if.
`default_nettype none

module clock_time_set_controller
  import ctsc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ctsc_chan_if.sink                  req,
  ctsc_chan_if.source                res
);

`include "clock_time_set_controller_assert.svh"

  localparam int unsigned PHASE_W =
    ($clog2(TICKS_PER_SECOND) > 4) ? $clog2(TICKS_PER_SECOND) : 4;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SECOND - 1);
  localparam logic [PHASE_W-1:0] PHASE_MIN  = PHASE_W'(MINUTE_PHASE);
  // Phase after a tick from the minute-setting value, which may lie past the wrap
  localparam logic [PHASE_W-1:0] PHASE_AFTER_MIN =
    PHASE_W'((MINUTE_PHASE + 1) % TICKS_PER_SECOND);
  localparam logic MIN_PAST_WRAP = (MINUTE_PHASE >= TICKS_PER_SECOND);

  // Configuration registers
  logic [TIMEOUT_W-1:0] idle_limit;
  logic [HOLD_W-1:0]    hold_to_set;
  logic [HOLD_W-1:0]    short_press;

  // Controller state
  logic [PHASE_W-1:0]   tick_phase,   tick_phase_next;
  logic                 reload_due,   reload_due_next;
  logic [TIMEOUT_W-1:0] awake_left,   awake_left_next;
  logic [HOLD_W-1:0]    hold_ticks,   hold_ticks_next;
  logic [MODE_W-1:0]    set_mode,     set_mode_next;
  logic [HOUR_W-1:0]    hour_count,   hour_count_next;
  logic [MINUTE_W-1:0]  minute_count, minute_count_next;
  logic                 asleep,       asleep_next;
  logic                 write_next;

  // Result slot
  logic res_valid;
  res_t res_data;
  logic accept;
  logic [PHASE_W+PHASE_OUT_W-1:0] phase_ext;

  assign req.ready   = ~res_valid | res.ready;
  assign accept      = req.valid & req.ready;
  assign res.valid   = res_valid;
  assign res.payload = res_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit  <= IDLE_LIMIT_RESET;
      hold_to_set <= HOLD_TO_SET_RESET;
      short_press <= SHORT_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_LIMIT:  idle_limit  <= cfg_data;
        CFG_HOLD_TO_SET: hold_to_set <= cfg_data[HOLD_W-1:0];
        CFG_SHORT_PRESS: short_press <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Compute the full state update for one request
  always_comb begin
    logic run;
    logic [TIMEOUT_W-1:0] margin;
    tick_phase_next   = tick_phase;
    reload_due_next   = reload_due;
    awake_left_next   = awake_left;
    hold_ticks_next   = hold_ticks;
    set_mode_next     = set_mode;
    hour_count_next   = hour_count;
    minute_count_next = minute_count;
    asleep_next       = asleep;
    write_next        = 1'b0;
    run               = 1'b1;
    margin            = idle_limit - TIMEOUT_W'(hold_to_set);

    if (asleep) begin
      // Wake on a button change and reload the time; ignore ticks
      if (req.payload.req_type == REQ_BUTTON) begin
        hold_ticks_next   = '0;
        awake_left_next   = idle_limit;
        hour_count_next   = (req.payload.rtc_hour > HOUR_MAX) ? '0 : req.payload.rtc_hour;
        minute_count_next = (req.payload.rtc_minute > MINUTE_MAX) ?
                            '0 : req.payload.rtc_minute;
        asleep_next       = 1'b0;
      end else begin
        run = 1'b0;
      end
    end else if (req.payload.req_type == REQ_BUTTON) begin
      hold_ticks_next = '0;
      awake_left_next = idle_limit;
    end else begin
      // Advance phase, count down awake time, count the hold
      if (MIN_PAST_WRAP && tick_phase == PHASE_MIN) begin
        tick_phase_next = PHASE_AFTER_MIN;
      end else if (tick_phase >= PHASE_LAST) begin
        tick_phase_next = '0;
      end else begin
        tick_phase_next = tick_phase + 1'b1;
      end
      if (tick_phase_next == '0) begin
        reload_due_next = 1'b1;
      end
      if (awake_left != '0) begin
        awake_left_next = awake_left - 1'b1;
      end
      if (!req.payload.button_down) begin
        hold_ticks_next = '0;
      end else if (hold_ticks != HOLD_SAT) begin
        hold_ticks_next = hold_ticks + 1'b1;
      end
    end

    if (run) begin
      // Setting machine
      unique case (set_mode_next)
        MODE_HOUR: begin
          tick_phase_next = '0;
          if (hold_ticks_next > short_press) begin
            hour_count_next = (hour_count_next >= HOUR_MAX) ? '0 : hour_count_next + 1'b1;
            hold_ticks_next = '0;
            awake_left_next = idle_limit;
          end
        end
        MODE_MINUTE: begin
          tick_phase_next = PHASE_MIN;
          if (hold_ticks_next > short_press) begin
            minute_count_next = (minute_count_next >= MINUTE_MAX) ?
                                '0 : minute_count_next + 1'b1;
            hold_ticks_next = '0;
            awake_left_next = idle_limit;
          end
        end
        default: begin
          if (hold_ticks_next > hold_to_set) begin
            set_mode_next   = MODE_HOUR;
            hold_ticks_next = '0;
            awake_left_next = idle_limit;
          end else if (reload_due_next) begin
            hour_count_next   = (req.payload.rtc_hour > HOUR_MAX) ?
                                '0 : req.payload.rtc_hour;
            minute_count_next = (req.payload.rtc_minute > MINUTE_MAX) ?
                                '0 : req.payload.rtc_minute;
            reload_due_next   = 1'b0;
          end
        end
      endcase

      // Advance on inactivity
      if (set_mode_next != MODE_CLOCK && idle_limit > TIMEOUT_W'(hold_to_set) &&
          awake_left_next < margin) begin
        set_mode_next   = set_mode_next + 1'b1;
        hold_ticks_next = '0;
        awake_left_next = idle_limit;
      end
      // Leave minute setting and request the RTC write
      if (set_mode_next == MODE_DONE) begin
        write_next      = 1'b1;
        set_mode_next   = MODE_CLOCK;
        hold_ticks_next = '0;
        awake_left_next = idle_limit;
      end
      // Sleep when the awake time runs out
      if (awake_left_next == '0) begin
        asleep_next = 1'b1;
      end
    end
  end

  // Update state on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase   <= '0;
      reload_due   <= 1'b0;
      awake_left   <= '0;
      hold_ticks   <= '0;
      set_mode     <= MODE_CLOCK;
      hour_count   <= HOUR_RESET;
      minute_count <= '0;
      asleep       <= 1'b0;
    end else if (accept) begin
      tick_phase   <= tick_phase_next;
      reload_due   <= reload_due_next;
      awake_left   <= awake_left_next;
      hold_ticks   <= hold_ticks_next;
      set_mode     <= set_mode_next;
      hour_count   <= hour_count_next;
      minute_count <= minute_count_next;
      asleep       <= asleep_next;
    end
  end

  assign phase_ext = {{PHASE_OUT_W{1'b0}}, tick_phase_next};

  // Hold the result until taken; load a new one on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.shown_hour   <= hour_count_next;
      res_data.shown_minute <= minute_count_next;
      res_data.mode         <= set_mode_next;
      res_data.colon_phase  <= phase_ext[PHASE_OUT_W-1:0];
      res_data.led_color    <= asleep_next ? LED_OFF : set_mode_next;
      res_data.rtc_write    <= write_next;
      res_data.display_on   <= ~asleep_next;
    end
  end

  `CTSC_ASSERT_NEXT(a_accept_fills_slot, accept, res_valid,
    "accepted transaction did not produce a result")
  `CTSC_ASSERT_NOW(a_mode_range, 1'b1, set_mode != MODE_DONE,
    "setting mode stuck past minute setting")
  `CTSC_ASSERT_NOW(a_time_range, 1'b1,
    hour_count <= HOUR_MAX && minute_count <= MINUTE_MAX,
    "held time out of range")
  `CTSC_ASSERT_NOW(a_sleep_result, res_valid && !res_data.display_on,
    res_data.led_color == LED_OFF && !res_data.rtc_write,
    "asleep result shows LED or requests a write")
  `CTSC_ASSERT_NOW(a_write_in_clock, res_valid && res_data.rtc_write,
    res_data.mode == MODE_CLOCK && res_data.led_color == MODE_CLOCK,
    "RTC write requested outside clock mode")

endmodule

`default_nettype wire

/* sim/clock_time_set_controller_checker.sv */
// Scoreboard for the clock/time-set controller: watches the register port and both
// channels, predicts every result and compares it. Depends on ctsc_pkg.
`default_nettype none

module clock_time_set_controller_checker
  import ctsc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  req_valid,
  input  wire logic                  req_ready,
  input  wire req_t                  req_payload,
  input  wire logic                  res_valid,
  input  wire logic                  res_ready,
  input  wire res_t                  res_payload,
  output int unsigned                errors,
  output int unsigned                pending,
  output int unsigned                live_items,
  output int unsigned                checked,
  output int unsigned                rtc_writes
);

  // Register copies
  logic [TIMEOUT_W-1:0] sleep_ticks;
  logic [HOLD_W-1:0]    enter_margin;
  logic [HOLD_W-1:0]    step_hold;

  // Watch state
  logic [7:0]           phase_q;
  logic                 reload_pending;
  logic [TIMEOUT_W-1:0] awake_left;
  logic [HOLD_W-1:0]    hold_count;
  logic [MODE_W-1:0]    set_mode;
  logic [HOUR_W-1:0]    hour_now;
  logic [MINUTE_W-1:0]  minute_now;
  logic                 dozing;

  res_t        expected_display[$];
  int unsigned err_cnt;
  int unsigned live_cnt;
  int unsigned checked_cnt;
  int unsigned write_cnt;

  // Restart the hold count and the awake timer
  function void rearm_awake();
    hold_count = '0;
    awake_left = sleep_ticks;
  endfunction

  // Take the time from the RTC fields, out-of-range values read as zero
  function void load_rtc_time(input req_t rq);
    hour_now   = (rq.rtc_hour > HOUR_MAX) ? '0 : rq.rtc_hour;
    minute_now = (rq.rtc_minute > MINUTE_MAX) ? '0 : rq.rtc_minute;
  endfunction

  // Run the setting machine once; return the RTC write request
  function logic run_set_machine(input req_t rq);
    logic wr;
    wr = 1'b0;
    if (set_mode == MODE_HOUR) begin
      phase_q = '0;
      if (hold_count > step_hold) begin
        hour_now = (hour_now == HOUR_MAX) ? '0 : hour_now + 1'b1;
        rearm_awake();
      end
    end else if (set_mode == MODE_MINUTE) begin
      phase_q = 8'(MINUTE_PHASE);
      if (hold_count > step_hold) begin
        minute_now = (minute_now == MINUTE_MAX) ? '0 : minute_now + 1'b1;
        rearm_awake();
      end
    end else begin
      if (hold_count > enter_margin) begin
        set_mode = MODE_HOUR;
        rearm_awake();
      end else if (reload_pending) begin
        load_rtc_time(rq);
        reload_pending = 1'b0;
      end
    end
    // Advance on inactivity, only when the timeout is above the margin
    if (set_mode != MODE_CLOCK && sleep_ticks > enter_margin &&
        awake_left < sleep_ticks - enter_margin) begin
      set_mode = set_mode + 1'b1;
      rearm_awake();
    end
    if (set_mode == MODE_DONE) begin
      wr = 1'b1;
      set_mode = MODE_CLOCK;
      rearm_awake();
    end
    return wr;
  endfunction

  // Apply one request to the watch state and build the display it yields
  function res_t next_display(input req_t rq);
    res_t r;
    logic wr;
    wr = 1'b0;
    if (dozing) begin
      if (rq.req_type == REQ_BUTTON) begin
        rearm_awake();
        load_rtc_time(rq);
        dozing = 1'b0;
        wr = run_set_machine(rq);
        if (awake_left == '0) dozing = 1'b1;
      end
    end else begin
      if (rq.req_type == REQ_BUTTON) begin
        rearm_awake();
      end else begin
        phase_q = 8'((int'(phase_q) + 1) % TICKS_PER_SECOND);
        if (phase_q == '0) reload_pending = 1'b1;
        if (awake_left != '0) awake_left = awake_left - 1'b1;
        if (!rq.button_down) hold_count = '0;
        else if (hold_count != HOLD_SAT) hold_count = hold_count + 1'b1;
      end
      wr = run_set_machine(rq);
      if (awake_left == '0) dozing = 1'b1;
    end
    r.shown_hour   = hour_now;
    r.shown_minute = minute_now;
    r.mode         = set_mode;
    r.colon_phase  = phase_q[PHASE_OUT_W-1:0];
    r.led_color    = dozing ? LED_OFF : set_mode;
    r.rtc_write    = wr;
    r.display_on   = !dozing;
    return r;
  endfunction

  // Count a mismatch; report only the first few
  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("MISMATCH %s at %0t: expected %0d, got %0d", field, $time, want, got);
  endtask

  // Track registers, predict on each request, compare on each result
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      sleep_ticks    = IDLE_LIMIT_RESET;
      enter_margin   = HOLD_TO_SET_RESET;
      step_hold      = SHORT_PRESS_RESET;
      phase_q        = '0;
      reload_pending = 1'b0;
      awake_left     = '0;
      hold_count     = '0;
      set_mode       = MODE_CLOCK;
      hour_now       = HOUR_RESET;
      minute_now     = '0;
      dozing         = 1'b0;
      expected_display.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDLE_LIMIT:  sleep_ticks = cfg_data;
          CFG_HOLD_TO_SET: enter_margin = cfg_data[HOLD_W-1:0];
          CFG_SHORT_PRESS: step_hold = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        if (!(dozing && req_payload.req_type == REQ_TICK)) live_cnt++;
        expected_display.push_back(next_display(req_payload));
      end
      if (res_valid && res_ready) begin
        if (expected_display.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("UNEXPECTED result at %0t: %p", $time, res_payload);
        end else begin
          want = expected_display.pop_front();
          checked_cnt++;
          if (res_payload.rtc_write) write_cnt++;
          if (res_payload.shown_hour != want.shown_hour)
            note_mismatch("shown_hour", want.shown_hour, res_payload.shown_hour);
          if (res_payload.shown_minute != want.shown_minute)
            note_mismatch("shown_minute", want.shown_minute, res_payload.shown_minute);
          if (res_payload.mode != want.mode)
            note_mismatch("mode", want.mode, res_payload.mode);
          if (res_payload.colon_phase != want.colon_phase)
            note_mismatch("colon_phase", want.colon_phase, res_payload.colon_phase);
          if (res_payload.led_color != want.led_color)
            note_mismatch("led_color", want.led_color, res_payload.led_color);
          if (res_payload.rtc_write != want.rtc_write)
            note_mismatch("rtc_write", want.rtc_write, res_payload.rtc_write);
          if (res_payload.display_on != want.display_on)
            note_mismatch("display_on", want.display_on, res_payload.display_on);
        end
      end
    end
    // Publish counters after the edge so readers never race the update
    errors     <= err_cnt;
    pending    <= expected_display.size();
    live_items <= live_cnt;
    checked    <= checked_cnt;
    rtc_writes <= write_cnt;
  end

  initial begin
    err_cnt     = 0;
    live_cnt    = 0;
    checked_cnt = 0;
    write_cnt   = 0;
    errors      = 0;
    pending     = 0;
    live_items  = 0;
    checked     = 0;
    rtc_writes  = 0;
  end

endmodule

`default_nettype wire

/* sim/clock_time_set_controller_tb.sv */
// Top of the clock/time-set controller bench: clock, reset, stimulus, verdict.
// Depends on ctsc_pkg, ctsc_chan_if, the controller RTL and the checker module.
`default_nettype none

module clock_time_set_controller_tb;
  import ctsc_pkg::*;

  localparam int unsigned TICKS_PER_SECOND = 30;
  localparam int unsigned WATCHDOG_LIMIT   = 1000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ctsc_chan_if #(.payload_t(req_t)) req_ch ();
  ctsc_chan_if #(.payload_t(res_t)) res_ch ();

  int unsigned errors, pending, live_items, checked, rtc_writes;
  int unsigned quiet_cycles = 0;

  // Current register values, used to shape button gestures
  int unsigned sto_now = IDLE_LIMIT_RESET;
  int unsigned hts_now = HOLD_TO_SET_RESET;
  int unsigned sp_now  = SHORT_PRESS_RESET;
  bit          stall_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clock_time_set_controller #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  clock_time_set_controller_checker #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_payload (req_ch.payload),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_payload (res_ch.payload),
    .errors      (errors),
    .pending     (pending),
    .live_items  (live_items),
    .checked     (checked),
    .rtc_writes  (rtc_writes)
  );

  // Mostly short gaps, now and then a long one
  function int unsigned pick_gap();
    int unsigned r;
    if (!stall_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build a request; the RTC fields are mostly legal, sometimes anything
  function req_t make_req(input logic kind, input logic down);
    req_t r;
    r.req_type    = kind;
    r.button_down = down;
    if ($urandom_range(0, 4) == 0) begin
      r.rtc_hour   = 5'($urandom_range(0, 31));
      r.rtc_minute = 6'($urandom_range(0, 63));
    end else begin
      r.rtc_hour   = 5'($urandom_range(0, HOUR_MAX));
      r.rtc_minute = 6'($urandom_range(0, MINUTE_MAX));
    end
    return r;
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_req(input req_t item);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One gesture: a press, held ticks, a release and quiet ticks, or some noise
  task automatic run_gesture();
    int unsigned held, quiet, r, k;
    if ($urandom_range(0, 99) < 15) stall_on = !stall_on;
    if ($urandom_range(0, 99) < 70) begin
      send_req(make_req(REQ_BUTTON, 1'b1));
      case ($urandom_range(0, 3))
        0:       held = $urandom_range(0, sp_now);
        1:       held = sp_now + 1 + $urandom_range(0, sp_now);
        2:       held = hts_now + $urandom_range(0, 2);
        default: held = hts_now + 1 + $urandom_range(1, 3 * (sp_now + 1));
      endcase
      if (held > 270) held = 270;
      for (k = 0; k < held; k++) send_req(make_req(REQ_TICK, 1'b1));
      send_req(make_req(REQ_BUTTON, 1'b0));
      r = $urandom_range(0, 9);
      if (r < 6) quiet = $urandom_range(0, 4);
      else if (r < 9) quiet = hts_now + $urandom_range(1, 2);
      else quiet = sto_now + $urandom_range(0, 2);
      if (quiet > 300) quiet = 300;
      for (k = 0; k < quiet; k++) send_req(make_req(REQ_TICK, 1'b0));
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) send_req(make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
  endtask

  // Reprogram all registers while idle, then run gestures for a while
  task automatic run_phase(input int unsigned sto, input int unsigned hts,
                           input int unsigned sp, input int unsigned target);
    int unsigned goal;
    wait_drained();
    write_reg(CFG_IDLE_LIMIT, sto);
    write_reg(CFG_HOLD_TO_SET, hts);
    write_reg(CFG_SHORT_PRESS, sp);
    sto_now = sto;
    hts_now = hts;
    sp_now  = sp;
    goal = live_items + target;
    while (live_items < goal) run_gesture();
  endtask

  // Result side: random stalls, with stretches of none
  initial begin
    int unsigned off_len, on_len;
    res_ch.ready = 1'b0;
    forever begin
      off_len = pick_gap();
      if (off_len > 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (off_len - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      on_len = $urandom_range(1, 12);
      repeat (on_len - 1) @(negedge clk);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned goal;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Tick right after reset sleeps at once; asleep tick is ignored
    send_req('{REQ_TICK, 1'b0, 5'd0, 6'd0});
    send_req('{REQ_TICK, 1'b1, 5'd23, 6'd59});
    // Wake with out-of-range RTC fields, then release the button with the legal maxima
    send_req('{REQ_BUTTON, 1'b1, 5'd31, 6'd63});
    send_req('{REQ_BUTTON, 1'b0, 5'd23, 6'd59});
    send_req('{REQ_TICK, 1'b1, 5'd24, 6'd60});
    send_req('{REQ_TICK, 1'b1, 5'd0, 6'd0});
    send_req('{REQ_TICK, 1'b1, 5'd23, 6'd59});
    send_req('{REQ_BUTTON, 1'b0, 5'd5, 6'd17});
    send_req('{REQ_TICK, 1'b0, 5'd31, 6'd63});
    send_req('{REQ_TICK, 1'b0, 5'd16, 6'd32});
    send_req('{REQ_BUTTON, 1'b1, 5'd15, 6'd31});
    send_req('{REQ_TICK, 1'b0, 5'd0, 6'd59});
    send_req('{REQ_TICK, 1'b1, 5'd23, 6'd0});
    send_req('{REQ_BUTTON, 1'b0, 5'd10, 6'd45});

    // Reset register values first, then a spread of settings
    goal = live_items + 200;
    while (live_items < goal) run_gesture();
    run_phase(61, 1, 1, 200);
    run_phase(61, 254, 254, 150);
    run_phase(65535, 254, 1, 400);
    run_phase($urandom_range(61, 150), $urandom_range(1, 30), $urandom_range(1, 8), 250);
    run_phase($urandom_range(61, 400), $urandom_range(1, 80), $urandom_range(1, 20), 200);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Checked %0d results from %0d effective requests, %0d RTC writes seen",
             checked, live_items, rtc_writes);
    $display("Covered reset values and five register settings, range extremes included");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
